FILE: rtl/ffpa_pkg.sv
// ============================================================================
// ffpa_pkg
// Shared types and constants for the first-fit page allocator: command and
// status codes, payload widths and the configuration register map.
// ============================================================================
package ffpa_pkg;

    // Payload widths of the request and response channels.
    localparam int SIZE_W = 13;
    localparam int ADDR_W = 32;

    // Configuration port widths.
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    // Byte address of the page base register.
    localparam logic [APB_ADDR_W-1:0] REG_PAGE_BASE = '0;

    // Request commands.
    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    // Response status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_SIZE  = 2'd1,
        ST_NO_SPACE  = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } status_t;

endpackage

FILE: rtl/ffpa_if.sv
// ============================================================================
// ffpa_if
// Valid/ready channel interfaces for allocator requests and responses.
// ============================================================================

// Request channel: command, allocation size and address to release.
interface ffpa_req_if;
    import ffpa_pkg::*;

    logic                valid;
    logic                ready;
    cmd_t                cmd;
    logic [SIZE_W-1:0]   size_bytes;
    logic [ADDR_W-1:0]   free_address;

    modport source (output valid, output cmd, output size_bytes, output free_address,
                    input ready);
    modport sink   (input valid, input cmd, input size_bytes, input free_address,
                    output ready);
endinterface

// Response channel: status and granted address.
interface ffpa_rsp_if;
    import ffpa_pkg::*;

    logic                valid;
    logic                ready;
    status_t             status;
    logic [ADDR_W-1:0]   granted_address;

    modport source (output valid, output status, output granted_address, input ready);
    modport sink   (input valid, input status, input granted_address, output ready);
endinterface

FILE: rtl/ffpa_div.sv
// ============================================================================
// ffpa_div
// Divider by a constant through reciprocal multiplication. The dividend is
// captured on start, the quotient comes from one multiply by the rounded-up
// reciprocal, and the remainder from one multiply-back and subtract. Done
// is registered behind two phase registers that follow start. A dividend of
// more than IN_W bits returns an all-ones quotient and a zero remainder.
// ============================================================================
module ffpa_div #(
    parameter int DIVISOR = 8,
    parameter int IN_W    = 13
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ffpa_pkg::ADDR_W-1:0] dividend,
    output logic                        done,
    output logic [ffpa_pkg::ADDR_W-1:0] quotient,
    output logic [$clog2(DIVISOR+1)-1:0] remainder
);
    import ffpa_pkg::*;

    localparam int REM_W  = $clog2(DIVISOR + 1);
    localparam int SHIFT  = IN_W + $clog2(DIVISOR);
    localparam int RCP_W  = IN_W + 1;
    localparam int PROD_W = IN_W + RCP_W;
    localparam longint unsigned RCP_VAL =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RCP_W-1:0] RECIP  = RCP_W'(RCP_VAL);
    localparam logic [IN_W-1:0]  DIV_IN = IN_W'(DIVISOR);

    logic                ph1_reg,  ph1_next;
    logic                ph2_reg,  ph2_next;
    logic                done_reg, done_next;
    logic                over_reg, over_next;
    logic [IN_W-1:0]     x_reg,    x_next;
    logic [ADDR_W-1:0]   quo_reg,  quo_next;
    logic [REM_W-1:0]    rem_reg,  rem_next;
    logic [PROD_W-1:0]   product;
    logic [IN_W-1:0]     back_mul;
    logic [IN_W-1:0]     rem_full;

    // Quotient by reciprocal, then remainder by multiplying back.
    assign product  = PROD_W'(x_reg) * PROD_W'(RECIP);
    assign back_mul = quo_reg[IN_W-1:0] * DIV_IN;
    assign rem_full = x_reg - back_mul;

    always_comb
    begin
        ph1_next  = start;
        ph2_next  = ph1_reg;
        done_next = ph2_reg;
        x_next    = x_reg;
        over_next = over_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            x_next    = dividend[IN_W-1:0];
            over_next = (dividend[ADDR_W-1:IN_W] != '0);
        end
        if (ph1_reg)
        begin
            quo_next = over_reg ? '1 : ADDR_W'(product >> SHIFT);
        end
        if (ph2_reg)
        begin
            rem_next = over_reg ? '0 : REM_W'(rem_full);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph1_reg  <= 1'b0;
            ph2_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            ph1_reg  <= ph1_next;
            ph2_reg  <= ph2_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        over_reg <= over_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/first_fit_page_allocator.sv
// ============================================================================
// first_fit_page_allocator
// Allocate: a divide, a scan at one unit per cycle for the first free run,
// then one write per granted unit; a bad size skips the scan. Free: a divide,
// a read of the run start, then one write per unit of the run; no writes when
// no run starts there, and no read off the page or unit grid. One request at
// a time; the next is taken in the cycle after the response is loaded, later
// while it waits. Reset: a clearing pass frees every unit, requests held off.
// ============================================================================
module first_fit_page_allocator #(
    parameter int UNIT_BYTES = 8,
    parameter int UNIT_COUNT = 512
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ffpa_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ffpa_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ffpa_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    ffpa_req_if.sink                        req,
    ffpa_rsp_if.source                      rsp
);
    import ffpa_pkg::*;

    localparam int IDX_W = $clog2(UNIT_COUNT);
    localparam int CNT_W = $clog2(UNIT_COUNT + 1);
    localparam int REM_W = $clog2(UNIT_BYTES + 1);
    // Divider input width: covers every size and every in-page offset.
    localparam int PAGE_W   = $clog2(UNIT_COUNT * UNIT_BYTES);
    localparam int DIV_IN_W = (PAGE_W > SIZE_W) ? PAGE_W : SIZE_W;
    // Table entry: run length, run start flag, unit busy flag.
    localparam int ENT_W = CNT_W + 2;
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(UNIT_COUNT - 1);
    localparam logic [CNT_W-1:0] COUNT_END  = CNT_W'(UNIT_COUNT);
    localparam logic [CNT_W-1:0] ONE_CNT    = CNT_W'(1);
    localparam logic [ADDR_W-1:0] COUNT_LIM = ADDR_W'(UNIT_COUNT);
    localparam logic [ADDR_W-1:0] UNIT_SZ   = ADDR_W'(UNIT_BYTES);

    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_DIV      = 9'b000000100,
        S_SCAN     = 9'b000001000,
        S_MARK     = 9'b000010000,
        S_FREE_RD  = 9'b000100000,
        S_FREE_CHK = 9'b001000000,
        S_RELEASE  = 9'b010000000,
        S_DONE     = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   page_base_reg;
    cmd_t                cmd_reg, cmd_next;
    logic [CNT_W-1:0]    need_reg, need_next;
    logic [IDX_W-1:0]    base_idx_reg, base_idx_next;
    logic [IDX_W-1:0]    mark_ptr_reg, mark_ptr_next;
    logic [CNT_W-1:0]    mark_left_reg, mark_left_next;
    logic [CNT_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [IDX_W-1:0]    chk_ptr_reg, chk_ptr_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [CNT_W-1:0]    run_cnt_reg, run_cnt_next;
    status_t             res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic                rsp_valid_reg, rsp_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;

    // Unit table and its ports.
    logic [ENT_W-1:0]    unit_mem [UNIT_COUNT];
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [ENT_W-1:0]    mem_wdata;
    logic [IDX_W-1:0]    mem_raddr;
    logic [ENT_W-1:0]    mem_rdata_reg;

    // Divider ports.
    logic                div_start;
    logic [ADDR_W-1:0]   div_dividend;
    logic                div_done;
    logic [ADDR_W-1:0]   div_quo;
    logic [REM_W-1:0]    div_rem;

    logic                req_fire;
    logic                cfg_write;
    logic [CNT_W-1:0]    run_inc;
    logic [IDX_W-1:0]    first_idx;
    logic [ADDR_W-1:0]   grant_addr;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & (paddr == REG_PAGE_BASE);
    assign prdata    = (paddr == REG_PAGE_BASE) ? page_base_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_base_reg <= '0;
        end
        else if (cfg_write)
        begin
            page_base_reg <= pwdata;
        end
    end

    // Channel handshakes.
    assign req.ready           = (state_reg == S_IDLE);
    assign req_fire            = req.valid & (state_reg == S_IDLE);
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.granted_address = out_addr_reg;

    // Shared divider: size into units for allocate, offset into units for free.
    assign div_dividend = (req.cmd == CMD_FREE) ? (req.free_address - page_base_reg)
                                                : ADDR_W'(req.size_bytes);

    ffpa_div #(
        .DIVISOR (UNIT_BYTES),
        .IN_W    (DIV_IN_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Scan helpers: run length so far and where a found run starts.
    assign run_inc    = run_cnt_reg + ONE_CNT;
    assign first_idx  = IDX_W'(CNT_W'(chk_ptr_reg) + ONE_CNT - need_reg);
    assign grant_addr = page_base_reg + ADDR_W'(base_idx_reg) * UNIT_SZ;

    // Table read address: the scan pointer while scanning, else the run start.
    assign mem_raddr = (state_reg == S_SCAN) ? rd_ptr_reg[IDX_W-1:0] : base_idx_reg;

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        need_next       = need_reg;
        base_idx_next   = base_idx_reg;
        mark_ptr_next   = mark_ptr_reg;
        mark_left_next  = mark_left_reg;
        rd_ptr_next     = rd_ptr_reg;
        chk_ptr_next    = chk_ptr_reg;
        chk_vld_next    = 1'b0;
        run_cnt_next    = run_cnt_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        rsp_valid_next  = rsp_valid_reg & ~rsp.ready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        mem_we          = 1'b0;
        mem_waddr       = mark_ptr_reg;
        mem_wdata       = '0;
        div_start       = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // Mark every unit free and no run started.
                mem_we = 1'b1;
                if (mark_ptr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    mark_ptr_next = mark_ptr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (req_fire)
                begin
                    cmd_next   = req.cmd;
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    res_addr_next = '0;
                    if (cmd_reg == CMD_ALLOC)
                    begin
                        if ((div_rem != '0) || (div_quo == '0))
                        begin
                            res_status_next = ST_BAD_SIZE;
                            state_next      = S_DONE;
                        end
                        else if (div_quo > COUNT_LIM)
                        begin
                            res_status_next = ST_NO_SPACE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            need_next    = CNT_W'(div_quo);
                            rd_ptr_next  = '0;
                            run_cnt_next = '0;
                            state_next   = S_SCAN;
                        end
                    end
                    else
                    begin
                        if ((div_rem != '0) || (div_quo >= COUNT_LIM))
                        begin
                            res_status_next = ST_NOT_ALLOC;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            base_idx_next = IDX_W'(div_quo);
                            state_next    = S_FREE_RD;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                // Issue the next read while checking the entry read last cycle.
                if (rd_ptr_reg != COUNT_END)
                begin
                    rd_ptr_next  = rd_ptr_reg + ONE_CNT;
                    chk_ptr_next = rd_ptr_reg[IDX_W-1:0];
                    chk_vld_next = 1'b1;
                end
                if (chk_vld_reg)
                begin
                    if (mem_rdata_reg[0])
                    begin
                        run_cnt_next = '0;
                    end
                    else if (run_inc == need_reg)
                    begin
                        base_idx_next  = first_idx;
                        mark_ptr_next  = first_idx;
                        mark_left_next = need_reg;
                        chk_vld_next   = 1'b0;
                        state_next     = S_MARK;
                    end
                    else
                    begin
                        run_cnt_next = run_inc;
                    end
                end
                else if (rd_ptr_reg == COUNT_END)
                begin
                    res_status_next = ST_NO_SPACE;
                    state_next      = S_DONE;
                end
            end

            S_MARK:
            begin
                // Claim one unit per cycle; each carries the run length, the first the start flag.
                mem_we         = 1'b1;
                mem_wdata      = {need_reg, (mark_left_reg == need_reg), 1'b1};
                mark_ptr_next  = mark_ptr_reg + 1'b1;
                mark_left_next = mark_left_reg - ONE_CNT;
                if (mark_left_reg == ONE_CNT)
                begin
                    res_status_next = ST_OK;
                    res_addr_next   = grant_addr;
                    state_next      = S_DONE;
                end
            end

            S_FREE_RD:
            begin
                // The run start entry is being read.
                state_next = S_FREE_CHK;
            end

            S_FREE_CHK:
            begin
                if (!mem_rdata_reg[1])
                begin
                    res_status_next = ST_NOT_ALLOC;
                    state_next      = S_DONE;
                end
                else
                begin
                    mark_ptr_next  = base_idx_reg;
                    mark_left_next = mem_rdata_reg[ENT_W-1:2];
                    state_next     = S_RELEASE;
                end
            end

            S_RELEASE:
            begin
                // Return one unit per cycle, stopping at the end of the page.
                mem_we         = 1'b1;
                mark_ptr_next  = mark_ptr_reg + 1'b1;
                mark_left_next = mark_left_reg - ONE_CNT;
                if ((mark_left_reg <= ONE_CNT) || (mark_ptr_reg == LAST_IDX))
                begin
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                end
            end

            S_DONE:
            begin
                // Hand the result to the output register once it is free.
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            mark_ptr_reg  <= '0;
            chk_vld_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mark_ptr_reg  <= mark_ptr_next;
            chk_vld_reg   <= chk_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        need_reg       <= need_next;
        base_idx_reg   <= base_idx_next;
        mark_left_reg  <= mark_left_next;
        rd_ptr_reg     <= rd_ptr_next;
        chk_ptr_reg    <= chk_ptr_next;
        run_cnt_reg    <= run_cnt_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
    end

    // Unit table: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            unit_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= unit_mem[mem_raddr];
    end

endmodule
